// File: rtl/assert_macros.svh
// assertion helpers included by the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CPRA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CPRA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/cpra_pkg.sv
package cpra_pkg;

   localparam int WORD_BITS  = 32;
   localparam int LANE_BITS  = $clog2(WORD_BITS);
   localparam int PAGE_SHIFT = 12;
   localparam int COUNT_BITS = 13;
   localparam int ADDR_BITS  = 32;
   localparam int PAGES_REG_BITS = 13;
   localparam int CSR_INDEX_BITS = 2;
   localparam int DEFAULT_NUM_PAGES = 4096;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAGES_IN_USE = 2'd1;

   localparam logic [ADDR_BITS-1:0]      RESET_BASE_ADDRESS = 32'hC010_0000;
   localparam logic [PAGES_REG_BITS-1:0] RESET_PAGES_IN_USE = 13'd4096;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE        = 2'd0,
      STATUS_NO_SPACE    = 2'd1,
      STATUS_BAD_REQUEST = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_SETUP,
      ST_MARK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       clear_step;
      logic       scan_start;
      logic       scan_step;
      logic       latch_idx;
      logic       mark_setup;
      logic       mark_step;
      logic       rsp_load;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic count_zero;
      logic too_big;
      logic free_bad;
      logic is_free;
      logic scan_hit;
      logic scan_end;
      logic mark_end;
      logic rsp_free;
   } stat_type;

endpackage

// File: rtl/cpra_bitmap_ram.sv
module cpra_bitmap_ram #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [cpra_pkg::WORD_BITS-1:0] wr_data,
   input  logic [AW-1:0]                  rd_addr,
   output logic [cpra_pkg::WORD_BITS-1:0] rd_data
);

   logic [cpra_pkg::WORD_BITS-1:0] mem [DEPTH];
   logic [cpra_pkg::WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cpra_datapath.sv
`include "assert_macros.svh"

module cpra_datapath #(
   parameter int NUM_PAGES = cpra_pkg::DEFAULT_NUM_PAGES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cpra_pkg::cmd_type                    cmd,
   output cpra_pkg::stat_type                   stat,
   input  logic                                 req_operation,
   input  logic [cpra_pkg::COUNT_BITS-1:0]      req_page_count,
   input  logic [cpra_pkg::ADDR_BITS-1:0]       req_free_address,
   input  logic                                 csr_valid,
   input  logic [cpra_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cpra_pkg::ADDR_BITS-1:0]       csr_data,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic [cpra_pkg::ADDR_BITS-1:0]       rsp_run_address
);

   localparam int W     = cpra_pkg::WORD_BITS;
   localparam int LB    = cpra_pkg::LANE_BITS;
   localparam int WORDS = (NUM_PAGES + W - 1) / W;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int XW    = WAW + LB;
   localparam int LW    = $clog2(NUM_PAGES + 1);
   localparam int RW    = $clog2(NUM_PAGES + W);
   localparam int CW    = ((RW > cpra_pkg::COUNT_BITS) ? RW : cpra_pkg::COUNT_BITS) + 1;
   localparam int IW    = cpra_pkg::ADDR_BITS - cpra_pkg::PAGE_SHIFT;
   localparam int SW    = IW + 1;

   // configuration and request registers
   logic [cpra_pkg::ADDR_BITS-1:0]      base_ff, base_in;
   logic [cpra_pkg::PAGES_REG_BITS-1:0] pages_ff, pages_in;
   cpra_pkg::op_type                    op_ff, op_in;
   logic [cpra_pkg::COUNT_BITS-1:0]     count_ff, count_in;
   logic [cpra_pkg::ADDR_BITS-1:0]      addr_ff, addr_in;

   // run bounds
   logic [XW-1:0] anchor_ff, anchor_in;
   logic [XW-1:0] first_ff, first_in;
   logic [XW-1:0] last_ff, last_in;

   // word pipeline over the bitmap ram
   logic [WAW-1:0] word_ff, word_in;
   logic           iss_ff, iss_in;
   logic           dv_ff, dv_in;
   logic [WAW-1:0] ev_ff, ev_in;
   logic [RW-1:0]  run_ff, run_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   cpra_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [cpra_pkg::ADDR_BITS-1:0] rsp_addr_ff, rsp_addr_in;

   logic           wr_en;
   logic [WAW-1:0] wr_addr;
   logic [W-1:0]   wr_data;
   logic [W-1:0]   rd_data;

   logic [LW-1:0]  limit;
   logic [XW-1:0]  lim_m1;
   logic [WAW-1:0] scan_last_word;
   logic [LB-1:0]  scan_last_lane;
   logic [WAW-1:0] stop_word;
   logic [XW-1:0]  cnt_x;
   logic [XW-1:0]  first_calc;
   logic [XW-1:0]  last_calc;

   logic                           below_base;
   logic [cpra_pkg::ADDR_BITS-1:0] addr_diff;
   logic [IW-1:0]                  page_idx;

   logic [W-1:0]  hit_vec;
   logic          any_hit;
   logic [LB-1:0] hit_lane;
   logic [RW-1:0] run_next;
   logic [W-1:0]  run_mask;

   cpra_bitmap_ram #(
      .DEPTH (WORDS),
      .AW    (WAW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (word_ff),
      .rd_data (rd_data)
   );

   // managed size and its last page
   always_comb begin
      if (CW'(pages_ff) > CW'(NUM_PAGES)) begin
         limit = LW'(NUM_PAGES);
      end else begin
         limit = LW'(pages_ff);
      end
      lim_m1         = XW'(limit) - XW'(1);
      scan_last_word = lim_m1[XW-1:LB];
      scan_last_lane = lim_m1[LB-1:0];
      cnt_x          = XW'(count_ff);
      stop_word      = cmd.mark_step ? last_ff[XW-1:LB] : scan_last_word;
   end

   // free range check
   always_comb begin
      below_base = addr_ff < base_ff;
      addr_diff  = addr_ff - base_ff;
      page_idx   = addr_diff[cpra_pkg::ADDR_BITS-1:cpra_pkg::PAGE_SHIFT];
   end

   // per-lane run detection on one bitmap word
   always_comb begin
      logic [W-1:0]  fr;
      logic          nz [LB+1][W];
      logic [LB-1:0] zp [LB+1][W];
      logic [CW-1:0] need;
      int            s;
      for (int j = 0; j < W; j++) begin
         fr[j]    = ~rd_data[j] & ((ev_ff != scan_last_word) || (LB'(j) <= scan_last_lane));
         nz[0][j] = ~fr[j];
         zp[0][j] = LB'(j);
      end
      // nearest used page at or below each lane, doubling span each level
      for (int k = 0; k < LB; k++) begin
         s = 1 << k;
         for (int j = 0; j < W; j++) begin
            if (!nz[k][j] && (j >= s)) begin
               nz[k+1][j] = nz[k][(j >= s) ? j - s : 0];
               zp[k+1][j] = zp[k][(j >= s) ? j - s : 0];
            end else begin
               nz[k+1][j] = nz[k][j];
               zp[k+1][j] = zp[k][j];
            end
         end
      end
      need = CW'(count_ff) - CW'(run_ff);
      for (int j = 0; j < W; j++) begin
         if (nz[LB][j]) begin
            hit_vec[j] = CW'(LB'(j) - zp[LB][j]) >= CW'(count_ff);
         end else begin
            hit_vec[j] = CW'(j + 1) >= need;
         end
      end
      hit_lane = '0;
      for (int j = W - 1; j >= 0; j--) begin
         if (hit_vec[j]) begin
            hit_lane = LB'(j);
         end
      end
      any_hit = |hit_vec;
      if (nz[LB][W-1]) begin
         run_next = RW'(LB'(W - 1) - zp[LB][W-1]);
      end else begin
         run_next = run_ff + RW'(W);
      end
   end

   // run bounds and the write mask of the word in flight
   always_comb begin
      logic [LB-1:0] lo;
      logic [LB-1:0] hi;
      if (op_ff == cpra_pkg::OP_ALLOC) begin
         first_calc = anchor_ff + XW'(1) - cnt_x;
         last_calc  = anchor_ff;
      end else begin
         first_calc = anchor_ff;
         last_calc  = anchor_ff + cnt_x - XW'(1);
      end
      lo = (ev_ff == first_ff[XW-1:LB]) ? first_ff[LB-1:0] : '0;
      hi = (ev_ff == last_ff[XW-1:LB]) ? last_ff[LB-1:0] : '1;
      run_mask = ({W{1'b1}} << lo) & ({W{1'b1}} >> (LB'(W - 1) - hi));
   end

   always_comb begin
      wr_en   = cmd.clear_step || (cmd.mark_step && dv_ff);
      wr_addr = cmd.clear_step ? word_ff : ev_ff;
      if (cmd.clear_step) begin
         wr_data = '0;
      end else if (op_ff == cpra_pkg::OP_ALLOC) begin
         wr_data = rd_data | run_mask;
      end else begin
         wr_data = rd_data & ~run_mask;
      end
   end

   always_comb begin
      stat.clear_last = word_ff == WAW'(WORDS - 1);
      stat.count_zero = count_ff == '0;
      stat.too_big    = CW'(count_ff) > CW'(limit);
      stat.free_bad   = below_base || ((SW'(page_idx) + SW'(count_ff)) > SW'(limit));
      stat.is_free    = op_ff == cpra_pkg::OP_FREE;
      stat.scan_hit   = dv_ff && any_hit;
      stat.scan_end   = dv_ff && (ev_ff == scan_last_word) && !any_hit;
      stat.mark_end   = dv_ff && (ev_ff == last_ff[XW-1:LB]);
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      base_in       = base_ff;
      pages_in      = pages_ff;
      op_in         = op_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      anchor_in     = anchor_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      word_in       = word_ff;
      iss_in        = iss_ff;
      dv_in         = dv_ff;
      ev_in         = ev_ff;
      run_in        = run_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;

      if (csr_valid) begin
         case (csr_index)
            cpra_pkg::CSR_BASE_ADDRESS: base_in  = csr_data;
            cpra_pkg::CSR_PAGES_IN_USE: pages_in = csr_data[cpra_pkg::PAGES_REG_BITS-1:0];
            default: ;
         endcase
      end

      if (cmd.load_req) begin
         op_in    = cpra_pkg::op_type'(req_operation);
         count_in = req_page_count;
         addr_in  = req_free_address;
      end

      if (cmd.clear_step) begin
         word_in = word_ff + WAW'(1);
      end

      if (cmd.scan_start) begin
         word_in = '0;
         iss_in  = 1'b1;
         dv_in   = 1'b0;
         run_in  = '0;
      end

      if (cmd.latch_idx) begin
         anchor_in = page_idx[XW-1:0];
      end

      if (cmd.mark_setup) begin
         first_in = first_calc;
         last_in  = last_calc;
         word_in  = first_calc[XW-1:LB];
         iss_in   = 1'b1;
         dv_in    = 1'b0;
      end

      // one word read per cycle, evaluated in the next cycle
      if (cmd.scan_step || cmd.mark_step) begin
         dv_in = iss_ff;
         ev_in = word_ff;
         if (iss_ff) begin
            if (word_ff == stop_word) begin
               iss_in = 1'b0;
            end else begin
               word_in = word_ff + WAW'(1);
            end
         end
      end

      if (cmd.scan_step && dv_ff) begin
         if (any_hit) begin
            anchor_in = {ev_ff, hit_lane};
         end else begin
            run_in = run_next;
         end
      end

      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.code;
         if ((cmd.code == cpra_pkg::STATUS_DONE) && (op_ff == cpra_pkg::OP_ALLOC)) begin
            rsp_addr_in = base_ff +
               (cpra_pkg::ADDR_BITS'(first_ff) << cpra_pkg::PAGE_SHIFT);
         end else begin
            rsp_addr_in = '0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= cpra_pkg::RESET_BASE_ADDRESS;
         pages_ff     <= cpra_pkg::RESET_PAGES_IN_USE;
         word_ff      <= '0;
         iss_ff       <= 1'b0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         pages_ff     <= pages_in;
         word_ff      <= word_in;
         iss_ff       <= iss_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      count_ff      <= count_in;
      addr_ff       <= addr_in;
      anchor_ff     <= anchor_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      ev_ff         <= ev_in;
      run_ff        <= run_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_run_address = rsp_addr_ff;

   `CPRA_ASSERT_IMP(a_mark_in_run, clock, reset, cmd.mark_step && dv_ff,
      (ev_ff >= first_ff[XW-1:LB]) && (ev_ff <= last_ff[XW-1:LB]),
      "mark write outside the run")
   `CPRA_ASSERT_IMP(a_scan_run_short, clock, reset, cmd.scan_step && dv_ff,
      CW'(run_ff) < CW'(count_ff), "carried run already covers the count")
   `CPRA_ASSERT_NXT(a_run_ordered, clock, reset, cmd.mark_setup,
      first_ff <= last_ff, "run start beyond run end")
   `CPRA_ASSERT_IMP(a_rsp_no_overwrite, clock, reset, cmd.rsp_load,
      !rsp_valid_ff || rsp_ready, "result overwritten before taken")

endmodule

// File: rtl/cpra_ctrl.sv
module cpra_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output cpra_pkg::cmd_type  cmd,
   input  cpra_pkg::stat_type stat
);

   cpra_pkg::state_type  state_ff, state_in;
   cpra_pkg::status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpra_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.code  = code_ff;

      case (state_ff)
         cpra_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = cpra_pkg::ST_IDLE;
            end
         end
         cpra_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = cpra_pkg::ST_CHECK;
            end
         end
         cpra_pkg::ST_CHECK: begin
            if (stat.count_zero) begin
               code_in  = cpra_pkg::STATUS_BAD_REQUEST;
               state_in = cpra_pkg::ST_RESP;
            end else if (!stat.is_free) begin
               if (stat.too_big) begin
                  code_in  = cpra_pkg::STATUS_NO_SPACE;
                  state_in = cpra_pkg::ST_RESP;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = cpra_pkg::ST_SCAN;
               end
            end else if (stat.free_bad) begin
               code_in  = cpra_pkg::STATUS_BAD_REQUEST;
               state_in = cpra_pkg::ST_RESP;
            end else begin
               cmd.latch_idx = 1'b1;
               state_in      = cpra_pkg::ST_SETUP;
            end
         end
         cpra_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit) begin
               state_in = cpra_pkg::ST_SETUP;
            end else if (stat.scan_end) begin
               code_in  = cpra_pkg::STATUS_NO_SPACE;
               state_in = cpra_pkg::ST_RESP;
            end
         end
         cpra_pkg::ST_SETUP: begin
            cmd.mark_setup = 1'b1;
            state_in       = cpra_pkg::ST_MARK;
         end
         cpra_pkg::ST_MARK: begin
            cmd.mark_step = 1'b1;
            if (stat.mark_end) begin
               code_in  = cpra_pkg::STATUS_DONE;
               state_in = cpra_pkg::ST_RESP;
            end
         end
         cpra_pkg::ST_RESP: begin
            // wait here only while the previous result is still unclaimed
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = cpra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cpra_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/contiguous_page_run_allocator.sv
// channel   ports                                                 direction
// req       req_valid/ready, operation, page_count, free_address  in
// rsp       rsp_valid/ready, status, run_address                  out
// csr       csr_valid/ready, index, data                          in
//
// after reset a clearing pass zeroes every bitmap word, one word per cycle, with req_ready low;
// csr writes are always taken. allocate: check, scan for a free run, setup, then a mark pass
// that sets the run's bits; free: check, setup, then a mark pass that clears the run's bits;
// zero count, oversize or bad range go from check straight to the result
// the rate is set by the bitmap ram, one 32-page word read per cycle
// a new transaction is taken while the last result waits; a stalled rsp holds the next in RESP
module contiguous_page_run_allocator #(
   parameter int NUM_PAGES = cpra_pkg::DEFAULT_NUM_PAGES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic [cpra_pkg::COUNT_BITS-1:0]     req_page_count,
   input  logic [cpra_pkg::ADDR_BITS-1:0]      req_free_address,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [cpra_pkg::ADDR_BITS-1:0]      rsp_run_address,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cpra_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cpra_pkg::ADDR_BITS-1:0]      csr_data
);

   cpra_pkg::cmd_type  cmd;
   cpra_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   cpra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   cpra_datapath #(
      .NUM_PAGES (NUM_PAGES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_page_count   (req_page_count),
      .req_free_address (req_free_address),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_run_address  (rsp_run_address)
   );

endmodule
